### rtl/ntpc_pkg.sv
`timescale 1ns / 1ps
package ntpc_pkg;

  localparam logic CMD_GFX = 1'b0;
  localparam logic CMD_PAL = 1'b1;

  localparam logic TGT_VRAM = 1'b0;
  localparam logic TGT_PAL  = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int PLANES = 4;
  localparam int PIXELS = 8;

  typedef struct packed {
    logic        cmd;
    logic [8:0]  position;
    logic [31:0] payload;
  } in_word_t;

  typedef struct packed {
    logic        target;
    logic [13:0] address;
    logic [15:0] value;
    logic        last;
  } out_word_t;

  // decoded job handed from front to back
  typedef struct packed {
    logic        kind;
    logic [13:0] base;
    logic [31:0] data;
  } job_t;

endpackage

### rtl/ntpc_front.sv
`timescale 1ns / 1ps
module ntpc_front import ntpc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [2:0] cfg_data,
  input  logic     src_valid,
  output logic     src_ready,
  input  in_word_t src_word,
  input  logic     q_full,
  output logic     push,
  output job_t     job
);

  logic [2:0] bank_slot;
  logic [3:0] tile;
  logic [3:0] y;
  logic [5:0] chr;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_slot <= 3'd0;
    end else if (cfg_we) begin
      bank_slot <= cfg_data;
    end
  end

  assign src_ready = !q_full;
  assign push      = src_valid && !q_full;

  assign tile = src_word.position[8:5];
  assign y    = src_word.position[4:1];
  assign chr  = {tile[3], y[3], tile[2:0], src_word.position[0]};

  always_comb begin
    job.kind = src_word.cmd;
    job.data = '0;
    if (src_word.cmd == CMD_PAL) begin
      job.base = {7'd0, bank_slot, src_word.position[3:0]};
      // rgb565 to bgr555, green drops its lsb
      job.data[15:0] = {1'b0, src_word.payload[4:0], src_word.payload[10:6],
                        src_word.payload[15:11]};
    end else begin
      job.base = {bank_slot, chr, 1'b0, y[2:0], 1'b0};
      for (int i = 0; i < PIXELS; i++) begin
        for (int j = 0; j < PLANES; j++) begin
          job.data[j*8 + 7 - i] = src_word.payload[28 - 4*i + j];
        end
      end
    end
  end

endmodule

### rtl/ntpc_queue.sv
`timescale 1ns / 1ps
module ntpc_queue import ntpc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/ntpc_back.sv
`timescale 1ns / 1ps
module ntpc_back import ntpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_word_t dst_word
);

  logic [1:0] step;
  logic       load;
  logic       final_step;
  out_word_t  result;

  assign load       = head_valid && (!dst_valid || dst_ready);
  assign final_step = (head_job.kind == CMD_PAL) ? (step == 2'd1) : (step == 2'd3);
  assign pop        = load && final_step;

  always_comb begin
    result.last = final_step;
    if (head_job.kind == CMD_PAL) begin
      result.target  = TGT_PAL;
      result.address = head_job.base | {6'd0, step[0], 7'd0};
      result.value   = head_job.data[15:0];
    end else begin
      result.target  = TGT_VRAM;
      result.address = head_job.base | {9'd0, step[1], 3'd0, step[0]};
      result.value   = {8'd0, head_job.data[step*8 +: 8]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 2'd0;
      dst_valid <= 1'b0;
    end else begin
      if (load) begin
        step      <= final_step ? 2'd0 : step + 2'd1;
        dst_valid <= 1'b1;
      end else if (dst_ready) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dst_word <= result;
    end
  end

endmodule

### rtl/nibble_tile_to_planar_converter_core.sv
`timescale 1ns / 1ps
// an input word taken is written into the job queue, then its first result word
// is loaded into the output register; a graphics word gives four results and a
// palette word two, one result per cycle unless dst_ready stalls the back end
// a two-entry job queue lets input words be taken while results are stalled
// reset: synchronous rst empties the queue and output, bank_slot returns to 0
module nibble_tile_to_planar_converter_core import ntpc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_data,
  input  logic       src_valid,
  output logic       src_ready,
  input  in_word_t   src_word,
  output logic       dst_valid,
  input  logic       dst_ready,
  output out_word_t  dst_word
);

  logic q_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  ntpc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  ntpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  ntpc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .dst_valid  (dst_valid),
    .dst_ready  (dst_ready),
    .dst_word   (dst_word)
  );

endmodule

### rtl/ntpc_checker.sv
`timescale 1ns / 1ps
module ntpc_checker import ntpc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      dst_valid,
  input logic      dst_ready,
  input out_word_t dst_word
);

  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_word))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result valid after reset");

  a_pal_pair: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_ready && dst_word.target == TGT_PAL |->
      dst_word.address[13:8] == 6'd0 && dst_word.address[7] == dst_word.last &&
      dst_word.value[15] == 1'b0)
    else $error("palette word out of order or out of range");

  a_gfx_plane: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_ready && dst_word.target == TGT_VRAM |->
      dst_word.value[15:8] == 8'd0 &&
      dst_word.last == (dst_word.address[4] && dst_word.address[0]))
    else $error("plane word out of order or too wide");

endmodule

bind nibble_tile_to_planar_converter_core ntpc_checker u_ntpc_checker (
  .clk       (clk),
  .rst       (rst),
  .dst_valid (dst_valid),
  .dst_ready (dst_ready),
  .dst_word  (dst_word)
);

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import ntpc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_WAIT    = 12;
  localparam int SETTLE      = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;
  logic       src_valid = 1'b0;
  logic       src_ready;
  in_word_t   src_word = '0;
  logic       dst_valid;
  logic       dst_ready = 1'b0;
  out_word_t  dst_word;

  out_word_t  expected_writes[$];
  out_word_t  oldest;
  logic [2:0] slot_model = '0;
  int         error_count = 0;
  int         cycle_count = 0;
  bit         no_idle = 1'b0;

  nibble_tile_to_planar_converter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .src_word  (src_word),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_word  (dst_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // expected writes for one accepted input word
  task automatic predict_writes(in_word_t w);
    out_word_t  r;
    logic [3:0] tile;
    logic [3:0] y;
    logic [5:0] chr;
    logic [13:0] base;
    logic [7:0] planes [PLANES];
    logic [6:0] idx;
    logic [15:0] c;
    if (w.cmd == CMD_PAL) begin
      c = w.payload[15:0];
      idx = {slot_model, w.position[3:0]};
      r.target  = TGT_PAL;
      r.value   = {1'b0, c[4:0], c[10:6], c[15:11]};
      r.address = {7'd0, idx};
      r.last    = 1'b0;
      expected_writes.push_back(r);
      r.address = 14'd128 + {7'd0, idx};
      r.last    = 1'b1;
      expected_writes.push_back(r);
    end else begin
      tile = w.position[8:5];
      y    = w.position[4:1];
      chr  = {2'b00, tile[2:0], 1'b0} + {tile[3], 5'd0} + {5'd0, w.position[0]} +
             (y[3] ? 6'd16 : 6'd0);
      base = {slot_model, 11'd0} + {3'd0, chr, 5'd0} + {10'd0, y[2:0], 1'b0};
      for (int j = 0; j < PLANES; j++) begin
        planes[j] = '0;
        for (int i = 0; i < PIXELS; i++) planes[j][7 - i] = w.payload[28 - 4 * i + j];
      end
      for (int j = 0; j < PLANES; j++) begin
        r.target  = TGT_VRAM;
        r.address = base + (j[1] ? 14'd16 : 14'd0) + {13'd0, j[0]};
        r.value   = {8'd0, planes[j]};
        r.last    = (j == PLANES - 1);
        expected_writes.push_back(r);
      end
    end
  endtask

  task automatic check_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      slot_model = '0;
    end else begin
      if (dst_valid && dst_ready) begin
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual %h", $time, dst_word);
          error_count++;
        end else begin
          oldest = expected_writes.pop_front();
          check_field("target", {15'd0, oldest.target}, {15'd0, dst_word.target});
          check_field("address", {2'd0, oldest.address}, {2'd0, dst_word.address});
          check_field("value", oldest.value, dst_word.value);
          check_field("last", {15'd0, oldest.last}, {15'd0, dst_word.last});
        end
      end
      if (src_valid && src_ready) predict_writes(src_word);
      if (cfg_we) slot_model = cfg_data;
    end
  end

  // result side stalls
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      stall = draw_wait();
      repeat (stall) begin
        @(negedge clk);
        dst_ready = 1'b0;
      end
      @(negedge clk);
      dst_ready = 1'b1;
      do @(posedge clk); while (!dst_valid);
    end
  end

  task automatic send_word(logic cmd, logic [8:0] position, logic [31:0] payload);
    int gap;
    in_word_t w;
    w.cmd      = cmd;
    w.position = position;
    w.payload  = payload;
    gap = draw_wait();
    if (gap > 0) begin
      @(negedge clk);
      src_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    src_valid = 1'b1;
    src_word  = w;
    do @(posedge clk); while (!src_ready);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    src_valid = 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_slot(logic [2:0] s);
    wait_idle();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = s;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // slot 0 straight out of reset
  task automatic test_default_slot();
    send_word(CMD_GFX, 9'd0, 32'h0000_0000);
    send_word(CMD_GFX, 9'd511, 32'hFFFF_FFFF);
    send_word(CMD_GFX, 9'd1, 32'h0123_4567);
    send_word(CMD_GFX, 9'd16, 32'h89AB_CDEF);
    send_word(CMD_GFX, 9'd287, 32'h8000_0001);
    send_word(CMD_PAL, 9'd0, 32'h0000_FFFF);
  endtask

  // channel extremes, green lsb drop, ignored upper bits
  task automatic test_palette_colors();
    set_slot(3'd5);
    send_word(CMD_PAL, 9'd15, 32'h0000_0000);
    send_word(CMD_PAL, 9'd1, 32'h0000_F800);
    send_word(CMD_PAL, 9'd2, 32'h0000_07E0);
    send_word(CMD_PAL, 9'd3, 32'h0000_001F);
    send_word(CMD_PAL, 9'd4, 32'h0000_0020);
    send_word(CMD_PAL, 9'd5, 32'h0000_07C0);
    send_word(CMD_PAL, 9'h1F0, 32'hFFFF_0000);
    send_word(CMD_PAL, 9'h1FF, 32'hFFFF_A5A5);
  endtask

  task automatic test_slot_extremes();
    set_slot(3'd7);
    send_word(CMD_GFX, 9'd511, 32'hFFFF_FFFF);
    send_word(CMD_GFX, 9'd480, 32'hF0F0_F0F0);
    send_word(CMD_PAL, 9'd15, 32'h0000_FFFF);
    set_slot(3'd0);
    send_word(CMD_GFX, 9'd256, 32'h1248_1248);
    send_word(CMD_GFX, 9'd31, 32'hEDB7_EDB7);
    send_word(CMD_PAL, 9'd0, 32'h0000_1234);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_slot(3'd7);
        1: set_slot(3'd0);
        default: set_slot(3'($urandom_range(0, 7)));
      endcase
      no_idle = (phase == 2);
      repeat (25) send_word(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                            $urandom);
      no_idle = 1'b0;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_default_slot();
    test_palette_colors();
    test_slot_extremes();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
